// ===== hdl/tse_pkg.sv =====
// Shared types, opcodes and sequencer states for the topological sort engine.
package tse_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int MAX_ARCS_DEF     = 256;

  localparam logic [1:0] OP_VERTEX = 2'd0;
  localparam logic [1:0] OP_ARC    = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  typedef logic [4:0] vidx_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] first_label;
    logic [7:0] head_label;
  } in_item_t;

  typedef struct packed {
    logic [7:0] vertex_label;
    vidx_t      vertex_index;
    logic       vertex_valid;
    logic       has_cycle;
    logic       last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ASRCH,
    ST_ALINK,
    ST_AWRITE,
    ST_SCAN,
    ST_POP,
    ST_POPW,
    ST_HEAD,
    ST_WALK,
    ST_ARC,
    ST_DEC,
    ST_EMIT,
    ST_NONE
  } state_t;

endpackage

// ===== hdl/tse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/topological_sort_engine.sv =====
// Topological sort engine: graph loader and Kahn sort sequencer over shared RAMs.
//
// Usage: feed items on the in_ channel (valid/stall). A vertex item appends a
// labelled vertex. An arc item searches the stored labels one per cycle, then,
// if both labels are found and the arc store has room, links the arc into the
// tail's list and bumps the head's in-degree. A run item scans all in-degrees,
// then for each ready vertex pops it from the stack, reads its label and
// list head and walks its outgoing arcs, decrementing each head's in-degree;
// each vertex leaves as one beat on the out_ channel, the final beat flagged
// last_result with has_cycle. A run that emits nothing returns one beat with
// vertex_valid low. The graph is cleared after every run.
// in_stall is high whenever the sequencer is busy; a finished beat waits in
// the output register while the receiver stalls, and the sequencer holds
// until it is taken. Load items are accepted while a beat still waits.
// Reset (rst_n low, synchronous) empties the graph and the output register;
// the RAMs need no clearing pass, entries are written before they are read.
module topological_sort_engine #(
  parameter int MAX_VERTICES = tse_pkg::MAX_VERTICES_DEF,
  parameter int MAX_ARCS     = tse_pkg::MAX_ARCS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tse_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tse_pkg::out_item_t out_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int LW = $clog2(MAX_ARCS + 1);
  localparam int AW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;

  tse_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] arc_count_r, arc_count_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [CW-1:0] emitted_r, emitted_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [VW-1:0] rd_idx_r, rd_idx_nxt;
  logic          tf_r, tf_nxt, hf_r, hf_nxt;
  logic [VW-1:0] t_r, t_nxt, h_r, h_nxt;
  logic [7:0]    tail_lab_r, tail_lab_nxt, head_lab_r, head_lab_nxt;
  logic [VW-1:0] v_r, v_nxt, k_r, k_nxt;
  logic [LW-1:0] a_r, a_nxt;
  logic [7:0]    label_r, label_nxt;

  logic               out_valid_r;
  tse_pkg::out_item_t out_data_r, out_nxt;
  logic               out_load, out_free;

  logic in_fire, issue, arc_ok;

  // RAM ports
  logic          lab_we;
  logic [VW-1:0] lab_waddr, lab_raddr;
  logic [7:0]    lab_wdata, lab_rdata;
  logic          lh_we;
  logic [VW-1:0] lh_waddr, lh_raddr;
  logic [LW-1:0] lh_wdata, lh_rdata;
  logic          deg_we;
  logic [VW-1:0] deg_waddr, deg_raddr;
  logic [LW-1:0] deg_wdata, deg_rdata;
  logic          arc_we;
  logic [AW-1:0] arc_waddr, arc_raddr;
  logic [VW+LW-1:0] arc_wdata, arc_rdata;
  logic          stk_we;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic [VW-1:0] stk_wdata, stk_rdata;

  assign in_stall  = (state_r != tse_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign issue     = (idx_r < count_r);
  assign arc_ok    = (arc_count_r < LW'(MAX_ARCS));

  tse_ram #(.WIDTH(8), .DEPTH(MAX_VERTICES)) u_labels (
    .clk, .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(lab_raddr), .rdata(lab_rdata)
  );

  tse_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_list_head (
    .clk, .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
    .raddr(lh_raddr), .rdata(lh_rdata)
  );

  tse_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_in_degree (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata)
  );

  tse_ram #(.WIDTH(VW + LW), .DEPTH(MAX_ARCS)) u_arcs (
    .clk, .we(arc_we), .waddr(arc_waddr), .wdata(arc_wdata),
    .raddr(arc_raddr), .rdata(arc_rdata)
  );

  tse_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tse_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.operation)
            tse_pkg::OP_ARC: state_nxt = tse_pkg::ST_ASRCH;
            tse_pkg::OP_RUN: state_nxt = tse_pkg::ST_SCAN;
            default:         state_nxt = tse_pkg::ST_IDLE;
          endcase
        end
      end
      tse_pkg::ST_ASRCH: begin
        if (!issue && !pend_r) begin
          state_nxt = (tf_r && hf_r && arc_ok) ? tse_pkg::ST_ALINK : tse_pkg::ST_IDLE;
        end
      end
      tse_pkg::ST_ALINK:  state_nxt = tse_pkg::ST_AWRITE;
      tse_pkg::ST_AWRITE: state_nxt = tse_pkg::ST_IDLE;
      tse_pkg::ST_SCAN: begin
        if (!issue && !pend_r) begin
          state_nxt = tse_pkg::ST_POP;
        end
      end
      tse_pkg::ST_POP: begin
        state_nxt = (sp_r == '0) ? tse_pkg::ST_NONE : tse_pkg::ST_POPW;
      end
      tse_pkg::ST_POPW: state_nxt = tse_pkg::ST_HEAD;
      tse_pkg::ST_HEAD: state_nxt = tse_pkg::ST_WALK;
      tse_pkg::ST_WALK: begin
        state_nxt = (a_r == '0) ? tse_pkg::ST_EMIT : tse_pkg::ST_ARC;
      end
      tse_pkg::ST_ARC: state_nxt = tse_pkg::ST_DEC;
      tse_pkg::ST_DEC: state_nxt = tse_pkg::ST_WALK;
      tse_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = (sp_r == '0) ? tse_pkg::ST_IDLE : tse_pkg::ST_POP;
        end
      end
      tse_pkg::ST_NONE: begin
        if (out_free) begin
          state_nxt = tse_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tse_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    count_nxt     = count_r;
    arc_count_nxt = arc_count_r;
    sp_nxt        = sp_r;
    emitted_nxt   = emitted_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    rd_idx_nxt    = rd_idx_r;
    tf_nxt        = tf_r;
    hf_nxt        = hf_r;
    t_nxt         = t_r;
    h_nxt         = h_r;
    tail_lab_nxt  = tail_lab_r;
    head_lab_nxt  = head_lab_r;
    v_nxt         = v_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    label_nxt     = label_r;
    out_load      = 1'b0;
    out_nxt       = out_data_r;

    lab_we = 1'b0; lab_waddr = VW'(count_r); lab_wdata = in_data.first_label;
    lab_raddr = VW'(idx_r);
    lh_we = 1'b0; lh_waddr = VW'(count_r); lh_wdata = '0; lh_raddr = t_r;
    deg_we = 1'b0; deg_waddr = VW'(count_r); deg_wdata = '0; deg_raddr = h_r;
    arc_we = 1'b0; arc_waddr = AW'(arc_count_r); arc_wdata = {h_r, lh_rdata};
    arc_raddr = AW'(a_r - LW'(1));
    stk_we = 1'b0; stk_waddr = VW'(sp_r); stk_wdata = rd_idx_r;
    stk_raddr = VW'(sp_r - CW'(1));

    case (state_r)
      tse_pkg::ST_IDLE: begin
        if (in_fire) begin
          tail_lab_nxt = in_data.first_label;
          head_lab_nxt = in_data.head_label;
          idx_nxt      = '0;
          pend_nxt     = 1'b0;
          tf_nxt       = 1'b0;
          hf_nxt       = 1'b0;
          if (in_data.operation == tse_pkg::OP_VERTEX && count_r < CW'(MAX_VERTICES)) begin
            lab_we    = 1'b1;
            lh_we     = 1'b1;
            deg_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
      end
      tse_pkg::ST_ASRCH: begin
        lab_raddr = VW'(idx_r);
        pend_nxt  = issue;
        if (issue) begin
          idx_nxt    = idx_r + CW'(1);
          rd_idx_nxt = VW'(idx_r);
        end
        // first match wins: latch only once
        if (pend_r) begin
          if (!tf_r && lab_rdata == tail_lab_r) begin
            tf_nxt = 1'b1;
            t_nxt  = rd_idx_r;
          end
          if (!hf_r && lab_rdata == head_lab_r) begin
            hf_nxt = 1'b1;
            h_nxt  = rd_idx_r;
          end
        end
      end
      tse_pkg::ST_ALINK: begin
        lh_raddr  = t_r;
        deg_raddr = h_r;
      end
      tse_pkg::ST_AWRITE: begin
        arc_we        = 1'b1;
        lh_we         = 1'b1;
        lh_waddr      = t_r;
        lh_wdata      = arc_count_r + LW'(1);
        deg_we        = 1'b1;
        deg_waddr     = h_r;
        deg_wdata     = deg_rdata + LW'(1);
        arc_count_nxt = arc_count_r + LW'(1);
      end
      tse_pkg::ST_SCAN: begin
        deg_raddr = VW'(idx_r);
        pend_nxt  = issue;
        if (issue) begin
          idx_nxt    = idx_r + CW'(1);
          rd_idx_nxt = VW'(idx_r);
        end
        if (pend_r && deg_rdata == '0) begin
          stk_we    = 1'b1;
          stk_wdata = rd_idx_r;
          sp_nxt    = sp_r + CW'(1);
        end
      end
      tse_pkg::ST_POP: begin
        if (sp_r != '0) begin
          sp_nxt = sp_r - CW'(1);
        end
      end
      tse_pkg::ST_POPW: begin
        v_nxt     = stk_rdata;
        lab_raddr = stk_rdata;
        lh_raddr  = stk_rdata;
      end
      tse_pkg::ST_HEAD: begin
        a_nxt     = lh_rdata;
        label_nxt = lab_rdata;
      end
      tse_pkg::ST_WALK: begin
        arc_raddr = AW'(a_r - LW'(1));
      end
      tse_pkg::ST_ARC: begin
        k_nxt     = arc_rdata[LW +: VW];
        a_nxt     = arc_rdata[LW-1:0];
        deg_raddr = arc_rdata[LW +: VW];
      end
      tse_pkg::ST_DEC: begin
        if (deg_rdata != '0) begin
          deg_we    = 1'b1;
          deg_waddr = k_r;
          deg_wdata = deg_rdata - LW'(1);
          if (deg_rdata == LW'(1)) begin
            stk_we    = 1'b1;
            stk_wdata = k_r;
            sp_nxt    = sp_r + CW'(1);
          end
        end
      end
      tse_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_nxt.vertex_label = label_r;
          out_nxt.vertex_index = tse_pkg::vidx_t'(v_r);
          out_nxt.vertex_valid = 1'b1;
          out_nxt.last_result  = (sp_r == '0);
          out_nxt.has_cycle    = (sp_r == '0) && ((emitted_r + CW'(1)) < count_r);
          emitted_nxt          = emitted_r + CW'(1);
          if (sp_r == '0) begin
            count_nxt     = '0;
            arc_count_nxt = '0;
            sp_nxt        = '0;
            emitted_nxt   = '0;
          end
        end
      end
      tse_pkg::ST_NONE: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_nxt.vertex_label = '0;
          out_nxt.vertex_index = '0;
          out_nxt.vertex_valid = 1'b0;
          out_nxt.last_result  = 1'b1;
          out_nxt.has_cycle    = (count_r != '0);
          count_nxt            = '0;
          arc_count_nxt        = '0;
          sp_nxt               = '0;
          emitted_nxt          = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tse_pkg::ST_IDLE;
      count_r     <= '0;
      arc_count_r <= '0;
      sp_r        <= '0;
      emitted_r   <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      tf_r        <= 1'b0;
      hf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      arc_count_r <= arc_count_nxt;
      sp_r        <= sp_nxt;
      emitted_r   <= emitted_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      tf_r        <= tf_nxt;
      hf_r        <= hf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    t_r        <= t_nxt;
    h_r        <= h_nxt;
    tail_lab_r <= tail_lab_nxt;
    head_lab_r <= head_lab_nxt;
    v_r        <= v_nxt;
    k_r        <= k_nxt;
    a_r        <= a_nxt;
    label_r    <= label_nxt;
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= count_r)
    else $error("ready stack deeper than vertex count");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (emitted_r + sp_r) <= (CW + 1)'(count_r))
    else $error("emitted plus stacked vertices exceed vertex count");

  a_arc_linked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tse_pkg::ST_ALINK) |-> (tf_r && hf_r && arc_ok))
    else $error("arc linked without both endpoints or room");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_nxt.last_result) |=>
      (count_r == '0 && arc_count_r == '0 && sp_r == '0 && state_r == tse_pkg::ST_IDLE))
    else $error("graph not cleared after final beat");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the topological sort engine: directed table, then random graphs.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_V        = tse_pkg::MAX_VERTICES_DEF;
  localparam int MAX_A        = tse_pkg::MAX_ARCS_DEF;
  localparam int RANDOM_ITEMS = 470;
  localparam int RUN_LIMIT    = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 60;
  localparam int DRAIN_CYCLES = 100;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam tse_pkg::out_item_t NO_RESULT = '0;
  localparam tse_pkg::out_item_t RUN_EMPTY = '{vertex_label: 8'h00, vertex_index: 5'd0,
    vertex_valid: 1'b0, has_cycle: 1'b0, last_result: 1'b1};
  localparam tse_pkg::out_item_t LONE_TOP  = '{vertex_label: 8'hFF, vertex_index: 5'd0,
    vertex_valid: 1'b1, has_cycle: 1'b0, last_result: 1'b1};
  localparam tse_pkg::out_item_t SELF_LOOP = '{vertex_label: 8'h00, vertex_index: 5'd0,
    vertex_valid: 1'b0, has_cycle: 1'b1, last_result: 1'b1};

  typedef struct {
    logic [1:0]         op;
    logic [7:0]         first;
    logic [7:0]         second;
    bit                 typed;
    tse_pkg::out_item_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  tse_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tse_pkg::out_item_t out_data;

  int send_idle_pct = 20;
  int recv_idle_pct = 54;
  int mismatches = 0;
  int results_taken = 0;
  int random_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit held_off = 1'b0;

  // graph mirror
  logic [7:0] pv_label [MAX_V];
  int         pv_list  [MAX_V];  // newest arc number plus one, 0 ends the list
  int         pv_indeg [MAX_V];
  int         pa_head  [MAX_A];
  int         pa_next  [MAX_A];
  int         pv_count = 0;
  int         pa_count = 0;

  tse_pkg::out_item_t run_order [$];
  tse_pkg::out_item_t order_due [$];
  dir_row_t           directed_rows [$];

  topological_sort_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int find_label(input logic [7:0] lbl);
    for (int i = 0; i < pv_count; i++)
      if (pv_label[i] == lbl) return i;
    return -1;
  endfunction

  // Update the mirror with one beat; a run leaves its emitted order in run_order.
  function automatic void apply_to_graph(input tse_pkg::in_item_t item);
    int t, h, v, a, depth, emitted;
    int ready [MAX_V];
    tse_pkg::out_item_t r;
    run_order.delete();
    case (item.operation)
      tse_pkg::OP_VERTEX: begin
        if (pv_count < MAX_V) begin
          pv_label[pv_count] = item.first_label;
          pv_list[pv_count]  = 0;
          pv_indeg[pv_count] = 0;
          pv_count++;
        end
      end
      tse_pkg::OP_ARC: begin
        t = find_label(item.first_label);
        h = find_label(item.head_label);
        if (t >= 0 && h >= 0 && pa_count < MAX_A) begin
          pa_head[pa_count] = h;
          pa_next[pa_count] = pv_list[t];
          pv_list[t] = pa_count + 1;
          pa_count++;
          pv_indeg[h]++;
        end
      end
      tse_pkg::OP_RUN: begin
        depth = 0;
        for (int i = 0; i < pv_count; i++) begin
          if (pv_indeg[i] == 0) begin
            ready[depth] = i;
            depth++;
          end
        end
        while (depth > 0) begin
          depth--;
          v = ready[depth];
          r = '0;
          r.vertex_label = pv_label[v];
          r.vertex_index = v[4:0];
          r.vertex_valid = 1'b1;
          run_order.push_back(r);
          for (a = pv_list[v]; a != 0; a = pa_next[a - 1]) begin
            h = pa_head[a - 1];
            if (pv_indeg[h] > 0) begin
              pv_indeg[h]--;
              if (pv_indeg[h] == 0) begin
                ready[depth] = h;
                depth++;
              end
            end
          end
        end
        // flag the final beat; an empty order becomes one status beat
        emitted = run_order.size();
        r = (emitted > 0) ? run_order.pop_back() : '0;
        r.has_cycle   = (emitted < pv_count);
        r.last_result = 1'b1;
        run_order.push_back(r);
        pv_count = 0;
        pa_count = 0;
        for (int i = 0; i < MAX_V; i++) pv_indeg[i] = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic dir_row_t row(input logic [1:0] op, input logic [7:0] first,
                                   input logic [7:0] second, input bit typed,
                                   input tse_pkg::out_item_t want);
    dir_row_t d;
    d.op = op;
    d.first = first;
    d.second = second;
    d.typed = typed;
    d.want = want;
    return d;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one beat, hold it until taken, then queue what it should produce.
  task automatic send_item(input logic [1:0] op, input logic [7:0] first,
                           input logic [7:0] second, input bit typed,
                           input tse_pkg::out_item_t want);
    tse_pkg::in_item_t item;
    item.operation   = op;
    item.first_label = first;
    item.head_label  = second;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_to_graph(item);
    if (typed) begin
      run_order.delete();
      run_order.push_back(want);
    end
    foreach (run_order[i]) order_due.push_back(run_order[i]);
  endtask

  // Load one graph of nv vertices and up to na arc beats, then run it.
  task automatic load_and_run(input int nv, input int na, input bit clean);
    logic [7:0] lbl [40];
    int rank [40];
    int i, j, t, h, tmp, pick;
    logic [7:0] u;
    for (i = 0; i < nv; i++) begin
      if (!clean && i > 0 && $urandom_range(9) == 0) lbl[i] = lbl[$urandom_range(i - 1)];
      else lbl[i] = 8'($urandom_range(255));
      rank[i] = i;
    end
    for (i = nv - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = rank[i];
      rank[i] = rank[j];
      rank[j] = tmp;
    end
    for (i = 0; i < nv; i++) begin
      if ($urandom_range(99) < 3)
        send_item(OP_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0,
                  NO_RESULT);
      send_item(tse_pkg::OP_VERTEX, lbl[i], 8'($urandom_range(255)), 1'b0, NO_RESULT);
      random_sent++;
    end
    for (i = 0; i < na && nv > 0; i++) begin
      pick = clean ? 99 : $urandom_range(99);
      t = $urandom_range(nv - 1);
      u = 8'($urandom_range(255));
      if (pick < 6) begin
        // likely unknown label on one end
        if (pick[0]) send_item(tse_pkg::OP_ARC, u, lbl[t], 1'b0, NO_RESULT);
        else send_item(tse_pkg::OP_ARC, lbl[t], u, 1'b0, NO_RESULT);
      end else if (nv >= 2) begin
        h = (t + 1 + $urandom_range(nv - 2)) % nv;
        if (pick == 6) h = t;
        else if (pick >= 12 && rank[t] > rank[h]) begin
          tmp = t;
          t = h;
          h = tmp;
        end
        send_item(tse_pkg::OP_ARC, lbl[t], lbl[h], 1'b0, NO_RESULT);
        random_sent++;
      end
    end
    send_item(tse_pkg::OP_RUN, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0,
              NO_RESULT);
    random_sent++;
  endtask

  initial begin : stimulus
    dir_row_t cur;
    bit verts_filled, arcs_filled;
    verts_filled = 1'b0;
    arcs_filled  = 1'b0;

    directed_rows.push_back(row(tse_pkg::OP_RUN,    8'h00, 8'h00, 1'b1, RUN_EMPTY));
    directed_rows.push_back(row(tse_pkg::OP_VERTEX, 8'hFF, 8'h00, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_RUN,    8'hFF, 8'hFF, 1'b1, LONE_TOP));
    directed_rows.push_back(row(tse_pkg::OP_VERTEX, 8'h00, 8'hFF, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_ARC,    8'h00, 8'h00, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_RUN,    8'h00, 8'h00, 1'b1, SELF_LOOP));
    directed_rows.push_back(row(OP_UNUSED,          8'hFF, 8'hFF, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_VERTEX, 8'hAA, 8'h00, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_VERTEX, 8'h55, 8'h00, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_VERTEX, 8'hAA, 8'h00, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_ARC,    8'hAA, 8'h55, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_ARC,    8'h55, 8'hAA, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_ARC,    8'h77, 8'h55, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_ARC,    8'hAA, 8'h77, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_RUN,    8'h00, 8'h00, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_VERTEX, 8'h00, 8'h00, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_VERTEX, 8'hFF, 8'h00, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_VERTEX, 8'h3C, 8'h00, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_ARC,    8'h3C, 8'hFF, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_ARC,    8'h3C, 8'h00, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_ARC,    8'hFF, 8'h00, 1'b0, NO_RESULT));
    directed_rows.push_back(row(tse_pkg::OP_RUN,    8'h00, 8'h00, 1'b0, NO_RESULT));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < directed_rows.size(); n++) begin
      cur = directed_rows[n];
      send_item(cur.op, cur.first, cur.second, cur.typed, cur.want);
    end

    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 54;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (!arcs_filled && random_sent >= 180) begin
        // overflow the arc store with a clean three-vertex graph
        load_and_run(3, MAX_A + 2, 1'b1);
        arcs_filled = 1'b1;
      end else if ((!verts_filled && random_sent >= 60) || $urandom_range(99) < 4) begin
        load_and_run($urandom_range(MAX_V + 1, MAX_V + 3), $urandom_range(40), 1'b0);
        verts_filled = 1'b1;
      end else if ($urandom_range(99) < 3) begin
        load_and_run(0, 0, 1'b0);
      end else begin
        load_and_run($urandom_range(1, 8), 0, 1'b0);
      end
    end
    in_valid <= 1'b0;

    while (order_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : drain
    tse_pkg::out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
        results_taken++;
        if (order_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = order_due.pop_front();
          check_field("vertex_label", int'(want.vertex_label),
                      int'(out_data.vertex_label));
          check_field("vertex_index", int'(want.vertex_index),
                      int'(out_data.vertex_index));
          check_field("vertex_valid", int'(want.vertex_valid),
                      int'(out_data.vertex_valid));
          check_field("has_cycle",    int'(want.has_cycle),
                      int'(out_data.has_cycle));
          check_field("last_result",  int'(want.last_result),
                      int'(out_data.last_result));
        end
        if (!held_off && results_taken == HOLD_AFTER) begin
          stall_left = HOLD_CYCLES;
          held_off = 1'b1;
        end
      end
      // hold off for a long stretch once so the block backs up into its input
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

endmodule
